// ===== hw/rtl/urqv_pkg.sv =====
`default_nettype none
package urqv_pkg;

  localparam int unsigned NUM_TARGET_REGS = 4;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned OUT_POS_W       = 16;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_HASH     = 8'h23;

  localparam logic [2:0] REG_TARGET_COUNT   = 3'd0;
  localparam logic [2:0] REG_TARGET_WORD_0  = 3'd1;
  localparam logic [2:0] REG_TARGET_WORD_1  = 3'd2;
  localparam logic [2:0] REG_TARGET_WORD_2  = 3'd3;
  localparam logic [2:0] REG_TARGET_WORD_3  = 3'd4;
  localparam logic [2:0] REG_TARGET_LENGTHS = 3'd5;

  localparam logic KIND_RANGE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [2:0]                             count;
    logic [NUM_TARGET_REGS-1:0][WORD_W-1:0] words;
    logic [15:0]                            lengths;
  } cfg_t;

  typedef struct packed {
    logic                 kind;
    logic [OUT_POS_W-1:0] first;
    logic [OUT_POS_W-1:0] last;
    logic                 esc;
    logic                 last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

// ===== hw/rtl/urqv_in_if.sv =====
`default_nettype none
interface urqv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       final_byte;

  modport source (output valid, output url_byte, output final_byte, input ready);
  modport sink (input valid, input url_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/urqv_out_if.sv =====
`default_nettype none
interface urqv_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] range_first;
  logic [15:0] range_last;
  logic        escaping_required;
  logic        last_result;

  modport source (output valid, output result_kind, output range_first, output range_last,
                  output escaping_required, output last_result, input ready);
  modport sink (input valid, input result_kind, input range_first, input range_last,
                input escaping_required, input last_result, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/url_query_value_redaction_scanner.sv =====
// Channel   Dir  Fields                                                  Beat
// url_in    in   url_byte[7:0], final_byte                               one URL byte
// result    out  result_kind, range_first[15:0], range_last[15:0],       one result
//                escaping_required, last_result
// One byte is accepted per cycle unless input stalls; the scan is combinational
// from the input register, and its results are written into the result queue.
// A byte that closes a redacted segment on the final byte yields two beats in a row.
// Input stalls only when the four-entry result queue holds more than two beats.
// Reset is synchronous; there is no clearing pass.
`default_nettype none
module url_query_value_redaction_scanner #(
  parameter int unsigned MAX_TARGETS    = 4,
  parameter int unsigned MAX_TARGET_LEN = 8,
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  urqv_in_if.sink          url_in,
  urqv_out_if.source       result
);

  urqv_pkg::cfg_t    cfg;
  urqv_pkg::push_t   push;
  urqv_pkg::result_t head;

  logic       inq_v;
  logic [7:0] inq_byte;
  logic       inq_fin;
  logic       room, not_empty, fire;

  assign fire         = inq_v && room;
  assign url_in.ready = !inq_v || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_v <= 1'b0;
    end else if (url_in.ready) begin
      inq_v <= url_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (url_in.ready && url_in.valid) begin
      inq_byte <= url_in.url_byte;
      inq_fin  <= url_in.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urqv_pkg::REG_TARGET_COUNT:   cfg.count    <= cfg_data[2:0];
        urqv_pkg::REG_TARGET_WORD_0:  cfg.words[0] <= cfg_data;
        urqv_pkg::REG_TARGET_WORD_1:  cfg.words[1] <= cfg_data;
        urqv_pkg::REG_TARGET_WORD_2:  cfg.words[2] <= cfg_data;
        urqv_pkg::REG_TARGET_WORD_3:  cfg.words[3] <= cfg_data;
        urqv_pkg::REG_TARGET_LENGTHS: cfg.lengths  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  urqv_core #(
    .MAX_TARGETS    (MAX_TARGETS),
    .MAX_TARGET_LEN (MAX_TARGET_LEN),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .url_byte   (inq_byte),
    .final_byte (inq_fin),
    .push       (push)
  );

  urqv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (result.ready),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  assign result.valid             = not_empty;
  assign result.result_kind       = head.kind;
  assign result.range_first       = head.first;
  assign result.range_last        = head.last;
  assign result.escaping_required = head.esc;
  assign result.last_result       = head.last_result;

endmodule
`default_nettype wire

// ===== hw/rtl/urqv_match.sv =====
`default_nettype none
module urqv_match #(
  parameter int unsigned MAX_TARGETS    = 4,
  parameter int unsigned MAX_TARGET_LEN = 8
) (
  input  wire urqv_pkg::cfg_t  cfg,
  input  wire logic [63:0]     recent,
  input  wire logic [3:0]      seg_len,
  output logic                 hit,
  output logic                 empty_hit
);

  localparam int unsigned LW = $clog2(MAX_TARGET_LEN + 1);

  logic [MAX_TARGETS-1:0] hit_k;
  logic [MAX_TARGETS-1:0] empty_k;

  for (genvar k = 0; k < MAX_TARGETS; k++) begin : g_target
    logic [3:0]              nib;
    logic [LW-1:0]           len;
    logic                    act;
    logic [MAX_TARGET_LEN:0] eq;

    assign nib = cfg.lengths[4*k +: 4];
    assign len = (nib > 4'(MAX_TARGET_LEN)) ? LW'(MAX_TARGET_LEN) : nib[LW-1:0];
    assign act = 3'(k) < cfg.count;
    assign eq[0] = 1'b0;

    for (genvar l = 1; l <= MAX_TARGET_LEN; l++) begin : g_len
      assign eq[l] = recent[64-8*l +: 8*l] == cfg.words[k][8*l-1:0];
    end

    assign hit_k[k]   = act && (len != '0) && (seg_len >= 4'(len)) && eq[len];
    assign empty_k[k] = act && (len == '0);
  end

  assign hit       = |hit_k;
  assign empty_hit = |empty_k;

endmodule
`default_nettype wire

// ===== hw/rtl/urqv_core.sv =====
`default_nettype none
module urqv_core #(
  parameter int unsigned MAX_TARGETS    = 4,
  parameter int unsigned MAX_TARGET_LEN = 8,
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire urqv_pkg::cfg_t cfg,
  input  wire logic           fire,
  input  wire logic [7:0]     url_byte,
  input  wire logic           final_byte,
  output urqv_pkg::push_t     push
);

  localparam int unsigned PW = POSITION_WIDTH;

  typedef enum logic [1:0] {PH_BEFORE, PH_QUERY, PH_AFTER} phase_t;

  phase_t        phase, phase_next;
  logic [PW-1:0] pos, pos_next, pos_inc;
  logic [PW-1:0] seg_start, seg_start_next;
  logic          pending, pending_next;
  logic          matched, matched_next;
  logic [63:0]   recent, recent_next, recent_shift;
  logic [3:0]    seg_len, seg_len_next, seg_len_inc;
  logic          any, any_next;

  logic          hit, empty_hit;
  logic          is_amp, is_hash, delim, nonempty, range_v;
  logic [PW-1:0] range_last;
  urqv_pkg::result_t range_r, verdict_r;

  assign pos_inc      = (pos == '1) ? pos : pos + PW'(1);
  assign recent_shift = {url_byte, recent[63:8]};
  assign seg_len_inc  = (seg_len == 4'hF) ? seg_len : seg_len + 4'd1;
  assign is_amp       = url_byte == urqv_pkg::CH_AMP;
  assign is_hash      = url_byte == urqv_pkg::CH_HASH;
  assign delim        = is_amp || is_hash;
  assign nonempty     = delim ? (pos > seg_start) : (pos >= seg_start);
  assign range_last   = delim ? pos - PW'(1) : pos;

  urqv_match #(
    .MAX_TARGETS    (MAX_TARGETS),
    .MAX_TARGET_LEN (MAX_TARGET_LEN)
  ) u_match (
    .cfg       (cfg),
    .recent    (recent_shift),
    .seg_len   (seg_len_inc),
    .hit       (hit),
    .empty_hit (empty_hit)
  );

  always_comb begin
    phase_next     = phase;
    seg_start_next = seg_start;
    pending_next   = pending;
    matched_next   = matched;
    recent_next    = recent;
    seg_len_next   = seg_len;
    any_next       = any;
    range_v        = 1'b0;

    unique case (phase)
      PH_BEFORE: begin
        if (url_byte == urqv_pkg::CH_QUESTION) begin
          phase_next     = PH_QUERY;
          seg_start_next = pos_inc;
          seg_len_next   = '0;
          matched_next   = 1'b0;
          recent_next    = '0;
        end
      end
      PH_QUERY: begin
        if (url_byte == urqv_pkg::CH_EQUALS) begin
          if ((seg_len != '0) && (matched || empty_hit)) begin
            pending_next = 1'b1;
          end
          seg_start_next = pos_inc;
          seg_len_next   = '0;
          matched_next   = 1'b0;
          recent_next    = '0;
        end else if (delim || final_byte) begin
          if (pending && nonempty) begin
            range_v  = 1'b1;
            any_next = 1'b1;
          end
          pending_next   = 1'b0;
          seg_start_next = pos_inc;
          seg_len_next   = '0;
          matched_next   = 1'b0;
          recent_next    = '0;
          if (is_hash) begin
            phase_next = PH_AFTER;
          end
        end else begin
          recent_next  = recent_shift;
          seg_len_next = seg_len_inc;
          if (hit) begin
            matched_next = 1'b1;
          end
        end
      end
      PH_AFTER: begin
      end
      default: begin
        phase_next = PH_BEFORE;
      end
    endcase

    pos_next = pos_inc;
    if (final_byte) begin
      phase_next     = PH_BEFORE;
      pos_next       = '0;
      seg_start_next = '0;
      pending_next   = 1'b0;
      matched_next   = 1'b0;
      recent_next    = '0;
      seg_len_next   = '0;
      any_next       = 1'b0;
    end
  end

  always_comb begin
    range_r.kind        = urqv_pkg::KIND_RANGE;
    range_r.first       = urqv_pkg::OUT_POS_W'(seg_start);
    range_r.last        = urqv_pkg::OUT_POS_W'(range_last);
    range_r.esc         = 1'b0;
    range_r.last_result = !final_byte;

    verdict_r.kind        = urqv_pkg::KIND_VERDICT;
    verdict_r.first       = '0;
    verdict_r.last        = '0;
    verdict_r.esc         = any || range_v;
    verdict_r.last_result = 1'b1;

    push.r0    = range_v ? range_r : verdict_r;
    push.r1    = verdict_r;
    push.count = fire ? (2'(range_v) + 2'(final_byte)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BEFORE;
      pos       <= '0;
      seg_start <= '0;
      pending   <= 1'b0;
      matched   <= 1'b0;
      recent    <= '0;
      seg_len   <= '0;
      any       <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      pos       <= pos_next;
      seg_start <= seg_start_next;
      pending   <= pending_next;
      matched   <= matched_next;
      recent    <= recent_next;
      seg_len   <= seg_len_next;
      any       <= any_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/urqv_fifo.sv =====
`default_nettype none
module urqv_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire urqv_pkg::push_t  push,
  input  wire logic             pop,
  output logic                  room,
  output logic                  not_empty,
  output urqv_pkg::result_t     head
);

  urqv_pkg::result_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       do_pop;

  assign not_empty = cnt != 3'd0;
  assign room      = cnt <= 3'd2;
  assign head      = mem[rp];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wp + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + push.count;
      rp  <= rp + 2'(do_pop);
      cnt <= cnt + 3'(push.count) - 3'(do_pop);
    end
  end

endmodule
`default_nettype wire
